// ===== sv/ukst_pkg.sv =====
// ----------------------------------------------------------------------------
// ukst_pkg
// Types, sizes and codes for the unique-key stack table
// ----------------------------------------------------------------------------
package ukst_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 16;
    localparam int AW         = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_FIND = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_POP  = 2'd2,
        CMD_DEL  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ABSENT = 3'd1,
        ST_DUP    = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_cmd                  cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [KEY_BITS-1:0]   out_key;
        logic [VALUE_BITS-1:0] out_value;
        logic [CNT_W-1:0]      count;
        logic                  is_empty;
    } t_res;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic t_res f_res(t_status st, logic [KEY_BITS-1:0] k,
                                   logic [VALUE_BITS-1:0] v, logic [CNT_W-1:0] c);
        t_res r;
        r.status    = st;
        r.out_key   = k;
        r.out_value = v;
        r.count     = c;
        r.is_empty  = (c == '0);
        return r;
    endfunction

endpackage

// ===== sv/ukst_ram.sv =====
// ----------------------------------------------------------------------------
// ukst_ram
// Simple dual-port RAM, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ukst_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 48,
    parameter int AW_P    = $clog2(DEPTH_P)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW_P-1:0]    i_waddr,
    input  logic [WIDTH_P-1:0] i_wdata,
    input  logic [AW_P-1:0]    i_raddr,
    output logic [WIDTH_P-1:0] o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/unique_key_stack_table_unit.sv =====
// ----------------------------------------------------------------------------
// unique_key_stack_table_unit
// Unique-key table in most-recent-first order: find, add, pop and delete
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  request   start, busy, i_req        taken when start high and busy low
//  result    o_done, o_res             o_done marks one cycle, no back pressure
//
//  entries sit in one RAM, oldest at address 0, newest at address count-1
//  find, add and delete scan the RAM one address a cycle, stopping at a hit
//  a delete then closes the gap one entry a cycle
//  pop reads the newest entry with no scan; commands on an empty table answer from idle
//  synchronous reset empties the table, RAM contents are left as they are
// ----------------------------------------------------------------------------
module unique_key_stack_table_unit
    import ukst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_done, n_done;
    t_res             r_res, n_res;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_entry           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry           rd_entry;
    logic             hit;
    logic             last;

    ukst_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign hit      = (rd_entry.key == r_req.key);
    assign last     = (CNT_W'(r_addr) == r_count - 1'b1);
    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_count   = r_count;
        n_addr    = r_addr;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = rd_entry;
        ram_raddr = r_addr + 1'b1;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
                if (start) begin
                    n_req = i_req;
                    if (r_count == '0) begin
                        n_done = 1'b1;
                        case (i_req.cmd)
                            CMD_FIND: n_res = f_res(ST_ABSENT, '0, '0, r_count);
                            CMD_ADD: begin
                                ram_we          = 1'b1;
                                ram_waddr       = '0;
                                ram_wdata.key   = i_req.key;
                                ram_wdata.value = i_req.value;
                                n_count         = CNT_W'(1);
                                n_res = f_res(ST_OK, '0, '0, CNT_W'(1));
                            end
                            default: n_res = f_res(ST_EMPTY, '0, '0, r_count);
                        endcase
                    end else if (i_req.cmd == CMD_POP) begin
                        ram_raddr = AW'(r_count - 1'b1);
                        n_state   = S_POP;
                    end else begin
                        n_addr  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_POP: begin
                n_count = r_count - 1'b1;
                n_res   = f_res(ST_OK, rd_entry.key, rd_entry.value, r_count - 1'b1);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (hit) begin
                    case (r_req.cmd)
                        CMD_FIND: begin
                            n_res   = f_res(ST_OK, rd_entry.key, rd_entry.value, r_count);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                        CMD_DEL: begin
                            n_res = f_res(ST_OK, rd_entry.key, rd_entry.value,
                                          r_count - 1'b1);
                            if (last) begin
                                n_count = r_count - 1'b1;
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_addr  = r_addr + 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_res   = f_res(ST_DUP, '0, '0, r_count);
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end else if (last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (r_req.cmd == CMD_ADD) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_res = f_res(ST_FULL, '0, '0, r_count);
                        end else begin
                            ram_we          = 1'b1;
                            ram_waddr       = AW'(r_count);
                            ram_wdata.key   = r_req.key;
                            ram_wdata.value = r_req.value;
                            n_count         = r_count + 1'b1;
                            n_res = f_res(ST_OK, '0, '0, r_count + 1'b1);
                        end
                    end else begin
                        n_res = f_res(ST_ABSENT, '0, '0, r_count);
                    end
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr - 1'b1;
                if (last) begin
                    n_count = r_count - 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + 1'b1 ||
                            r_count == $past(r_count) - 1'b1))
        else $error("entry count moved by more than one");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.is_empty == (o_res.count == '0) && o_res.count == r_count))
        else $error("result count disagrees with table state");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (busy || start))
        else $error("ram write without a request in progress");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result issued while still busy");

endmodule

// ===== tb/sv/tb_unique_key_stack_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_key_stack_table_unit
// Self-checking bench for the unique-key stack table
// ----------------------------------------------------------------------------
//  a queue of requests is built up front: a directed opening that walks the
//  table through empty, duplicate, full and the three delete positions, then
//  random phases that fill, drain or mix over a small key pool so hits,
//  duplicates and full-table refusals are common
//  a clocked driver issues the requests with random gap bursts, a clocked
//  monitor checks every result against a behavioral table kept in the bench
// ----------------------------------------------------------------------------
module tb_unique_key_stack_table_unit;
    import ukst_pkg::*;

    localparam int PERIOD     = 20;
    localparam int RESET_CYC  = 8;
    localparam int QUIET_TAIL = 150;
    localparam int DRAIN_WAIT = 60;
    localparam int STALL_MAX  = 2000;
    localparam int N_PHASES   = 20;
    localparam int PHASE_LEN  = 50;
    localparam int POOL_N     = 20;
    localparam int PRINT_MAX  = 100;

    typedef struct {
        t_req req;
        bit   drain;
    } t_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    t_item  req_q[$];
    t_res   result_q[$];
    t_entry tbl[DEPTH];
    int     tbl_count   = 0;
    int     n_issued    = 0;
    int     n_done      = 0;
    int     n_errors    = 0;
    int     gap_left    = 0;
    bit     gaps_on     = 1'b1;
    int     idle_cycles = 0;

    unique_key_stack_table_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial begin
        forever #(PERIOD / 2) i_clk = ~i_clk;
    end

    // table in most-recent-first order, slot 0 newest
    function automatic t_res table_apply(t_req r);
        t_res e;
        int   pos;
        bit   take;
        e.status    = ST_OK;
        e.out_key   = '0;
        e.out_value = '0;
        pos  = -1;
        take = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
            if (pos < 0 && tbl[i].key == r.key) pos = i;
        end
        case (r.cmd)
            CMD_FIND: begin
                if (pos < 0) begin
                    e.status = ST_ABSENT;
                end else begin
                    e.out_key   = tbl[pos].key;
                    e.out_value = tbl[pos].value;
                end
            end
            CMD_ADD: begin
                if (pos >= 0) begin
                    e.status = ST_DUP;
                end else if (tbl_count >= DEPTH) begin
                    e.status = ST_FULL;
                end else begin
                    for (int i = tbl_count; i > 0; i--) tbl[i] = tbl[i-1];
                    tbl[0].key   = r.key;
                    tbl[0].value = r.value;
                    tbl_count++;
                end
            end
            CMD_POP: begin
                if (tbl_count == 0) begin
                    e.status = ST_EMPTY;
                end else begin
                    pos  = 0;
                    take = 1'b1;
                end
            end
            CMD_DEL: begin
                if (tbl_count == 0) e.status = ST_EMPTY;
                else if (pos < 0) e.status = ST_ABSENT;
                else take = 1'b1;
            end
            default: ;
        endcase
        if (take) begin
            e.out_key   = tbl[pos].key;
            e.out_value = tbl[pos].value;
            for (int i = pos; i < tbl_count - 1; i++) tbl[i] = tbl[i+1];
            tbl_count--;
        end
        e.count    = CNT_W'(tbl_count);
        e.is_empty = (tbl_count == 0);
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (n_errors < PRINT_MAX)
            $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic queue_request(t_cmd c, logic [KEY_BITS-1:0] k,
                                 logic [VALUE_BITS-1:0] v, bit drain = 1'b0);
        t_item it;
        it.req.cmd   = c;
        it.req.key   = k;
        it.req.value = v;
        it.drain     = drain;
        req_q.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin
        bit    acc;
        int    outstanding;
        t_item it;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_req    <= '0;
            gap_left <= 0;
        end else begin
            acc = start && !busy;
            if (acc) begin
                result_q.push_back(table_apply(i_req));
                n_issued <= n_issued + 1;
            end
            if ($urandom_range(0, 63) == 0) gaps_on <= ~gaps_on;
            if (!start || acc) begin
                outstanding = n_issued + int'(acc) - n_done - int'(o_done === 1'b1);
                if (gap_left > 0) begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (req_q.size() == 0) begin
                    start <= 1'b0;
                end else if (req_q[0].drain && outstanding != 0) begin
                    start <= 1'b0;
                end else if (gaps_on && req_q.size() > QUIET_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    start    <= 1'b0;
                    gap_left <= $urandom_range(1, 12) - 1;
                end else begin
                    it = req_q.pop_front();
                    it.drain = 1'b0;
                    i_req <= it.req;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_done === 1'b1) begin
            n_done <= n_done + 1;
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_res), '0);
            end else begin
                e = result_q.pop_front();
                if (o_res.status !== e.status)
                    report_mismatch("status", 64'(o_res.status), 64'(e.status));
                if (o_res.out_key !== e.out_key)
                    report_mismatch("out_key", 64'(o_res.out_key), 64'(e.out_key));
                if (o_res.out_value !== e.out_value)
                    report_mismatch("out_value", 64'(o_res.out_value), 64'(e.out_value));
                if (o_res.count !== e.count)
                    report_mismatch("count", 64'(o_res.count), 64'(e.count));
                if (o_res.is_empty !== e.is_empty)
                    report_mismatch("is_empty", 64'(o_res.is_empty), 64'(e.is_empty));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done === 1'b1) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [KEY_BITS-1:0] key_pool[POOL_N];
        logic [KEY_BITS-1:0] k;
        int                  r;
        int                  mode;
        t_cmd                c;

        // empty table
        queue_request(CMD_FIND, 32'h0000_0000, 16'h0000);
        queue_request(CMD_POP,  32'hFFFF_FFFF, 16'hFFFF);
        queue_request(CMD_DEL,  32'hFFFF_FFFF, 16'hFFFF);
        // extremes, duplicate, hit and miss
        queue_request(CMD_ADD,  32'h0000_0000, 16'h0000);
        queue_request(CMD_ADD,  32'hFFFF_FFFF, 16'hFFFF);
        queue_request(CMD_ADD,  32'h0000_0000, 16'hA5A5);
        queue_request(CMD_FIND, 32'hFFFF_FFFF, 16'h0000);
        queue_request(CMD_FIND, 32'h8000_0001, 16'h0000);
        // fill to the top, then full and duplicate-on-full
        for (int i = 0; i < DEPTH - 2; i++)
            queue_request(CMD_ADD, KEY_BITS'(32'h1000 + i), VALUE_BITS'(16'h5A00 + i));
        queue_request(CMD_ADD,  32'h5555_5555, 16'h5555);
        queue_request(CMD_ADD,  32'hFFFF_FFFF, 16'hAAAA);
        // middle, oldest, newest and absent removals
        queue_request(CMD_DEL,  32'h1007,      16'h0000);
        queue_request(CMD_DEL,  32'h0000_0000, 16'h0000);
        queue_request(CMD_FIND, 32'h0000_0000, 16'h0000);
        queue_request(CMD_POP,  32'h0000_0000, 16'h0000);
        queue_request(CMD_DEL,  32'hDEAD_BEEF, 16'h0000);

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

        // fill, drain and mixed phases over the key pool
        for (int p = 0; p < N_PHASES; p++) begin
            mode = p % 3;
            for (int n = 0; n < PHASE_LEN; n++) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: c = (r < 70) ? CMD_ADD : (r < 80) ? CMD_FIND :
                           (r < 90) ? CMD_DEL : CMD_POP;
                    1: c = (r < 40) ? CMD_POP : (r < 75) ? CMD_DEL :
                           (r < 90) ? CMD_FIND : CMD_ADD;
                    default: c = t_cmd'(r % 4);
                endcase
                k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_N-1)]
                                                : KEY_BITS'($urandom);
                queue_request(c, k, VALUE_BITS'($urandom_range(0, 65535)),
                              n == 0 && (p == 5 || p == 12));
            end
        end

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (req_q.size() != 0 || start || n_issued != n_done) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        while (result_q.size() != 0) begin
            void'(result_q.pop_front());
            report_mismatch("result never arrived", '0, '0);
        end

        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ukst_pkg.sv
sv/ukst_ram.sv
sv/unique_key_stack_table_unit.sv
tb/sv/tb_unique_key_stack_table_unit.sv
